// ===== rtl/core/aar_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the axis-angle rotation block.
// No dependencies; imported by aar_norm, aar_cordic and axis_angle_rotation_matrix.
package aar_pkg;

    localparam int IN_W        = 16;
    localparam int AXIS_N      = 3;
    localparam int ISQRT_STEPS = 32;
    localparam int OUT_W       = 18;
    localparam int OUT_FRAC    = 16;
    localparam int MAT_N       = 9;
    localparam logic signed [OUT_W-1:0] OUT_ONE = 18'sd65536;

    typedef enum logic [1:0] {
        Q_0,
        Q_90,
        Q_180,
        Q_270
    } t_quad;

    typedef struct packed {
        logic       vld;
        logic       zero;
        logic [2:0] neg;
    } t_norm_st;

    typedef struct packed {
        logic                        zero;
        logic [MAT_N-1:0][OUT_W-1:0] r;
    } t_mat;

    function automatic int norm_latency(input int frac);
        return frac + ISQRT_STEPS + 6;
    endfunction

    function automatic int cordic_latency(input int steps);
        return steps + 2;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // CORDIC gain compensation, rounded to Q(frac)
    function automatic logic [31:0] cordic_gain(input int frac);
        logic [63:0] g;
        g = (64'd2608131496 + (64'd1 << (31 - frac))) >> (32 - frac);
        return g[31:0];
    endfunction

endpackage

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// Axis-angle to 3x3 rotation matrix (Rodrigues), fully pipelined.
// Depends on aar_pkg, aar_norm and aar_cordic.
//
// Usage:
//   Slave stream s_axis carries one axis and angle per transaction; master stream
//   m_axis returns the nine matrix entries in signed Q1.16 plus a zero-axis flag.
//   The path from accept to m_axis_tvalid runs through the 32-stage square root
//   and the FRAC_BITS + 1 stage divider ahead of the matrix multiplier stages.
//   CORDIC runs beside the normalizer behind a matching delay line.
//   Throughput is one transaction per cycle while s_axis_tready is high.
//   Output is a register slice with one skid entry: s_axis_tready drops only
//   once a result waits in the output register and a second one has arrived;
//   the whole pipeline then holds, nothing is lost or repeated.
//   An all-zero axis gives the identity matrix with m_axis_tuser set.
//   Reset (synchronous, active low) clears all valid bits; no data in flight
//   survives it.
module axis_angle_rotation_matrix #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // axis_x, axis_y, axis_z, turn_angle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic [0:0]   m_axis_tuser    // zero_axis
);
    import aar_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int UW    = F + 2;
    localparam int PW    = 2 * UW;
    localparam int OW    = F + 3;
    localparam int TPW   = UW + OW;
    localparam int TW    = F + 3;
    localparam int MW    = F + 4;
    localparam int RW    = TPW + 1;
    localparam int CVW   = MW + 8;
    localparam int ANG_D = norm_latency(F) - cordic_latency(CORDIC_STEPS);
    localparam int PAIR_N = 6;
    localparam int PA [PAIR_N] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [PAIR_N] = '{0, 1, 2, 1, 2, 2};
    localparam logic signed [CVW-1:0] SAT_HI = CVW'(65536);
    localparam logic signed [CVW-1:0] SAT_LO = -CVW'(65536);

    logic                    w_en;
    t_norm_st                w_nst;
    logic [2:0][F:0]         w_mag;
    logic signed [UW-1:0]    w_cos;
    logic signed [UW-1:0]    w_sin;

    logic [15:0]             r_ang [1:ANG_D];

    logic [5:0]              r_mv;
    logic [5:0]              r_mz;
    logic signed [UW-1:0]    r_u   [AXIS_N];
    logic signed [UW-1:0]    r_c   [0:4];
    logic signed [UW-1:0]    r_sn0;
    logic signed [OW-1:0]    r_omc [0:2];
    logic signed [PW-1:0]    r_pp  [PAIR_N];
    logic signed [PW-1:0]    r_ps  [AXIS_N];
    logic signed [UW-1:0]    r_p   [PAIR_N];
    logic signed [UW-1:0]    r_s   [2:4][AXIS_N];
    logic signed [TPW-1:0]   r_tp  [PAIR_N];
    logic signed [TW-1:0]    r_t   [PAIR_N];
    logic signed [MW-1:0]    r_m   [MAT_N];

    logic signed [CVW-1:0]   n_cv  [MAT_N];
    t_mat                    n_mat;
    logic                    n_push;

    t_mat                    r_out;
    t_mat                    r_skid;
    logic                    r_out_vld;
    logic                    r_skid_vld;

    function automatic logic signed [RW-1:0] rnd_shift(input logic signed [RW-1:0] p,
                                                       input int n);
        logic [RW-1:0] m;
        logic [RW-1:0] r;
        m = p[RW-1] ? RW'(-p) : RW'(p);
        r = (m + (RW'(1) << (n - 1))) >> n;
        return p[RW-1] ? -$signed(r) : $signed(r);
    endfunction

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    aar_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (s_axis_tvalid),
        .i_axis_x ($signed(s_axis_tdata[15:0])),
        .i_axis_y ($signed(s_axis_tdata[31:16])),
        .i_axis_z ($signed(s_axis_tdata[47:32])),
        .o_st     (w_nst),
        .o_mag    (w_mag)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang[1] <= s_axis_tdata[63:48];
            for (int d = 2; d <= ANG_D; d++) begin
                r_ang[d] <= r_ang[d-1];
            end
        end
    end

    aar_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_ang[ANG_D]),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (w_en) begin
            r_mv <= {r_mv[4:0], w_nst.vld};
        end
    end

    // matrix stages: sign, products, round, scale by 1-c, round, combine
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mz <= {r_mz[4:0], w_nst.zero};
            for (int l = 0; l < AXIS_N; l++) begin
                r_u[l] <= w_nst.neg[l] ? -$signed({1'b0, w_mag[l]}) : $signed({1'b0, w_mag[l]});
            end
            r_c[0]   <= w_cos;
            r_sn0    <= w_sin;
            r_omc[0] <= (OW'(1) <<< F) - OW'(w_cos);

            for (int i = 0; i < PAIR_N; i++) begin
                r_pp[i] <= PW'(r_u[PA[i]] * r_u[PB[i]]);
            end
            for (int l = 0; l < AXIS_N; l++) begin
                r_ps[l] <= PW'(r_u[l] * r_sn0);
            end
            r_c[1]   <= r_c[0];
            r_omc[1] <= r_omc[0];

            for (int i = 0; i < PAIR_N; i++) begin
                r_p[i] <= UW'(rnd_shift(RW'(r_pp[i]), F));
            end
            for (int l = 0; l < AXIS_N; l++) begin
                r_s[2][l] <= UW'(rnd_shift(RW'(r_ps[l]), F));
            end
            r_c[2]   <= r_c[1];
            r_omc[2] <= r_omc[1];

            for (int i = 0; i < PAIR_N; i++) begin
                r_tp[i] <= TPW'(r_p[i] * r_omc[2]);
            end
            r_s[3] <= r_s[2];
            r_c[3] <= r_c[2];

            for (int i = 0; i < PAIR_N; i++) begin
                r_t[i] <= TW'(rnd_shift(RW'(r_tp[i]), F));
            end
            r_s[4] <= r_s[3];
            r_c[4] <= r_c[3];

            r_m[0] <= MW'(r_c[4]) + MW'(r_t[0]);
            r_m[4] <= MW'(r_c[4]) + MW'(r_t[1]);
            r_m[8] <= MW'(r_c[4]) + MW'(r_t[2]);
            r_m[1] <= MW'(r_t[3]) - MW'(r_s[4][2]);
            r_m[3] <= MW'(r_t[3]) + MW'(r_s[4][2]);
            r_m[2] <= MW'(r_t[4]) + MW'(r_s[4][1]);
            r_m[6] <= MW'(r_t[4]) - MW'(r_s[4][1]);
            r_m[5] <= MW'(r_t[5]) - MW'(r_s[4][0]);
            r_m[7] <= MW'(r_t[5]) + MW'(r_s[4][0]);
        end
    end

    for (genvar i = 0; i < MAT_N; i++) begin : g_cv
        if (F > OUT_FRAC) begin : g_dn
            assign n_cv[i] = CVW'(rnd_shift(RW'(r_m[i]), F - OUT_FRAC));
        end else begin : g_up
            assign n_cv[i] = CVW'(r_m[i]) <<< (OUT_FRAC - F);
        end
    end

    always_comb begin
        n_mat.zero = r_mz[5];
        for (int i = 0; i < MAT_N; i++) begin
            if (r_mz[5]) begin
                n_mat.r[i] = (i % 4 == 0) ? OUT_ONE : '0;
            end else if (n_cv[i] > SAT_HI) begin
                n_mat.r[i] = OUT_ONE;
            end else if (n_cv[i] < SAT_LO) begin
                n_mat.r[i] = -OUT_ONE;
            end else begin
                n_mat.r[i] = n_cv[i][OUT_W-1:0];
            end
        end
    end

    assign n_push = w_en && r_mv[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out_vld <= n_push;
            end else if (n_push) begin
                r_skid_vld <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out <= n_mat;
            end else if (n_push) begin
                r_skid <= n_mat;
            end
        end else if (m_axis_tready) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out.r};
    assign m_axis_tuser  = r_out.zero;

    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without output entry");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    a_zero_identity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[17:0] == 18'd65536 && m_axis_tdata[35:18] == 18'd0 &&
             m_axis_tdata[89:72] == 18'd65536 && m_axis_tdata[161:144] == 18'd65536))
        else $error("zero axis did not give identity");

endmodule

// ===== rtl/core/aar_norm.sv =====
`timescale 1ns / 1ps
// Axis normalization pipeline: sum of squares, pipelined integer square root,
// pipelined restoring division per component. Depends on aar_pkg.
module aar_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [15:0]            i_axis_x,
    input  logic signed [15:0]            i_axis_y,
    input  logic signed [15:0]            i_axis_z,
    output aar_pkg::t_norm_st             o_st,
    output logic [2:0][FRAC_BITS:0]       o_mag
);
    import aar_pkg::*;

    localparam int QW  = FRAC_BITS + 1;
    localparam int NW  = FRAC_BITS + 34;
    localparam int LAT = norm_latency(FRAC_BITS);

    typedef struct packed {
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][IN_W-1:0]  mag;
        logic [4:0]            k;
    } t_side;

    logic [LAT:1] r_vld;

    logic signed [IN_W-1:0]   r_v    [AXIS_N];
    logic [2*IN_W-2:0]        r_sq   [AXIS_N];
    logic [2:0][IN_W-1:0]     r_mag1;
    logic [2:0]               r_neg1;
    logic [2*IN_W-1:0]        r_sum;
    logic [2:0][IN_W-1:0]     r_mag2;
    logic [2:0]               r_neg2;

    logic [63:0]              r_sq_s   [0:ISQRT_STEPS];
    logic [63:0]              r_sq_res [0:ISQRT_STEPS];
    t_side                    r_sd     [0:ISQRT_STEPS];

    logic [NW-1:0]            r_dv_n   [0:QW][AXIS_N];
    logic [QW-1:0]            r_dv_q   [0:QW][AXIS_N];
    logic [31:0]              r_dv_d   [0:QW];
    t_side                    r_dv_sd  [0:QW];

    logic signed [2*IN_W-1:0] n_prod   [AXIS_N];
    logic [IN_W:0]            n_abs    [AXIS_N];
    logic [4:0]               n_pos;
    logic [4:0]               n_k;
    logic [63:0]              n_big;
    logic [46:0]              n_mk     [AXIS_N];
    logic [NW-1:0]            n_num    [AXIS_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-1:1], i_vld};
        end
    end

    always_comb begin
        for (int l = 0; l < AXIS_N; l++) begin
            n_prod[l] = r_v[l] * r_v[l];
            n_abs[l]  = r_v[l][IN_W-1] ? (~{r_v[l][IN_W-1], r_v[l]} + 17'd1)
                                       : {1'b0, r_v[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= i_axis_x;
            r_v[1] <= i_axis_y;
            r_v[2] <= i_axis_z;
            for (int l = 0; l < AXIS_N; l++) begin
                r_sq[l]   <= n_prod[l][2*IN_W-2:0];
                r_mag1[l] <= n_abs[l][IN_W-1:0];
                r_neg1[l] <= r_v[l][IN_W-1];
            end
            r_sum  <= 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
    end

    // scale to [2^60, 2^62) by an even shift
    always_comb begin
        n_pos = '0;
        for (int p = 0; p < 32; p++) begin
            if (r_sum[p]) begin
                n_pos = 5'(p);
            end
        end
        n_k   = 5'((61 - int'(n_pos)) >> 1);
        n_big = {32'b0, r_sum} << {n_k, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_s[0]     <= n_big;
            r_sq_res[0]   <= '0;
            r_sd[0].zero  <= (r_sum == '0);
            r_sd[0].neg   <= r_neg2;
            r_sd[0].mag   <= r_mag2;
            r_sd[0].k     <= n_k;
        end
    end

    for (genvar j = 1; j <= ISQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (j - 1));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[j] <= r_sd[j-1];
                if (r_sq_s[j-1] >= r_sq_res[j-1] + BIT) begin
                    r_sq_s[j]   <= r_sq_s[j-1] - (r_sq_res[j-1] + BIT);
                    r_sq_res[j] <= (r_sq_res[j-1] >> 1) + BIT;
                end else begin
                    r_sq_s[j]   <= r_sq_s[j-1];
                    r_sq_res[j] <= r_sq_res[j-1] >> 1;
                end
            end
        end
    end

    // |v|*2^k never exceeds the root, so 31 bits hold it
    always_comb begin
        for (int l = 0; l < AXIS_N; l++) begin
            n_mk[l]  = {31'b0, r_sd[ISQRT_STEPS].mag[l]} << r_sd[ISQRT_STEPS].k;
            n_num[l] = (NW'(n_mk[l][30:0]) << (FRAC_BITS + 1))
                     + NW'(r_sq_res[ISQRT_STEPS][30:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_d[0]  <= {r_sq_res[ISQRT_STEPS][30:0], 1'b0};
            r_dv_sd[0] <= r_sd[ISQRT_STEPS];
            for (int l = 0; l < AXIS_N; l++) begin
                r_dv_n[0][l] <= n_num[l];
                r_dv_q[0][l] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int B = QW - j;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_d[j]  <= r_dv_d[j-1];
                r_dv_sd[j] <= r_dv_sd[j-1];
            end
        end
        for (genvar l = 0; l < AXIS_N; l++) begin : g_lane
            logic [NW-1:0] w_ds;
            assign w_ds = NW'(r_dv_d[j-1]) << B;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_dv_n[j-1][l] >= w_ds) begin
                        r_dv_n[j][l] <= r_dv_n[j-1][l] - w_ds;
                        r_dv_q[j][l] <= r_dv_q[j-1][l] | (QW'(1) << B);
                    end else begin
                        r_dv_n[j][l] <= r_dv_n[j-1][l];
                        r_dv_q[j][l] <= r_dv_q[j-1][l];
                    end
                end
            end
        end
    end

    always_comb begin
        o_st.vld  = r_vld[LAT];
        o_st.zero = r_dv_sd[QW].zero;
        o_st.neg  = r_dv_sd[QW].neg;
        for (int l = 0; l < AXIS_N; l++) begin
            o_mag[l] = r_dv_q[QW][l];
        end
    end

endmodule

// ===== rtl/core/aar_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: binary angle in, clamped cosine and sine out.
// Depends on aar_pkg (arctangent table, gain constant, quadrant type).
module aar_cordic #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [15:0]                 i_angle,
    output logic signed [FRAC_BITS+1:0] o_cos,
    output logic signed [FRAC_BITS+1:0] o_sin
);
    import aar_pkg::*;

    localparam int XW = FRAC_BITS + 3;
    localparam int ZW = 34;
    localparam int CW = FRAC_BITS + 2;
    localparam logic [31:0] GAIN = cordic_gain(FRAC_BITS);
    localparam logic signed [XW-1:0] ONE = XW'(1) << FRAC_BITS;

    logic signed [XW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    t_quad                r_q [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;

    logic [15:0]          n_t;
    logic signed [XW-1:0] n_c;
    logic signed [XW-1:0] n_s;

    function automatic logic signed [CW-1:0] clamp_one(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        c = (v > ONE) ? ONE : ((v < -ONE) ? -ONE : v);
        return CW'(c);
    endfunction

    // nearest quarter turn, residual in 2^-32 turn
    assign n_t = i_angle + 16'h2000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= t_quad'(n_t[15:14]);
            r_z[0] <= ZW'($signed({~n_t[13], n_t[12:0]})) <<< 16;
            r_x[0] <= $signed(XW'(GAIN));
            r_y[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic [31:0] ATAN = atan_turn(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed(ZW'(ATAN));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed(ZW'(ATAN));
                end
            end
        end
    end

    always_comb begin
        case (r_q[CORDIC_STEPS])
            Q_0: begin
                n_c = r_x[CORDIC_STEPS];
                n_s = r_y[CORDIC_STEPS];
            end
            Q_90: begin
                n_c = -r_y[CORDIC_STEPS];
                n_s = r_x[CORDIC_STEPS];
            end
            Q_180: begin
                n_c = -r_x[CORDIC_STEPS];
                n_s = -r_y[CORDIC_STEPS];
            end
            default: begin
                n_c = r_y[CORDIC_STEPS];
                n_s = -r_x[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= clamp_one(n_c);
            r_sin <= clamp_one(n_s);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule
